// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the core rtl file
// no dependencies; expands to nothing when SYNTHESIS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QTG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("qtg assertion failed");
`define QTG_ASSERT_IMPL(label, ante, cons) \
  `QTG_ASSERT(label, (ante) |-> (cons))
`else
`define QTG_ASSERT(label, prop)
`define QTG_ASSERT_IMPL(label, ante, cons)
`endif
`endif

// ----- hw/rtl/qtg_pkg.sv -----
// constants, types and basis tables of the quintic trajectory generator
// imported by every rtl module of the block
`default_nettype none

package qtg_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int DATA_WIDTH    = 32;
  localparam int GUARD_BITS    = 12;
  localparam int TAU_BITS      = 30;
  localparam int DUR_W         = DATA_WIDTH - 1;
  localparam int TERM_BITS     = 59;
  localparam int VAL_W         = TERM_BITS + 1;

  localparam int MUL_A_W   = VAL_W;
  localparam int MUL_B_W   = 42;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W + 1);

  localparam int DIV_N_W   = VAL_W + FRACTION_BITS;
  localparam int QUO_W     = VAL_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_N_W + 1);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_POSITION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACCEL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_POSITION   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_SPEED      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_ACCEL      = 3'd6;

  localparam logic [DUR_W-1:0] DURATION_RESET = DUR_W'(1) << FRACTION_BITS;

  // doubled hermite basis, [basis][derivative][power of tau] flattened
  localparam int BAS_STRIDE_I = 24;
  localparam int BAS_STRIDE_D = 6;
  localparam int BASIS_TAB [120] = '{
    0, 0, 0, 20, -30, 12,      0, 0, 60, -120, 60, 0,
    0, 120, -360, 240, 0, 0,   120, -720, 720, 0, 0, 0,
    0, 2, 0, -12, 16, -6,      2, 0, -36, 64, -30, 0,
    0, -72, 192, -120, 0, 0,   -72, 384, -360, 0, 0, 0,
    0, 0, 0, -8, 14, -6,       0, 0, -24, 56, -30, 0,
    0, -48, 168, -120, 0, 0,   -48, 336, -360, 0, 0, 0,
    0, 0, 1, -3, 3, -1,        0, 2, -9, 12, -5, 0,
    2, -18, 36, -20, 0, 0,     -18, 72, -60, 0, 0, 0,
    0, 0, 0, 1, -2, 1,         0, 0, 3, -8, 5, 0,
    0, 6, -24, 20, 0, 0,       6, -48, 60, 0, 0, 0
  };
  localparam int BASIS_TPOW [5] = '{0, 1, 1, 2, 2};

  typedef struct packed {
    logic [DUR_W-1:0]      duration;
    logic [DATA_WIDTH-1:0] start_position;
    logic [DATA_WIDTH-1:0] start_speed;
    logic [DATA_WIDTH-1:0] start_accel;
    logic [DATA_WIDTH-1:0] end_position;
    logic [DATA_WIDTH-1:0] end_speed;
    logic [DATA_WIDTH-1:0] end_accel;
  } qtg_cfg_t;

  typedef struct packed {
    logic             zero;
    logic [DUR_W-1:0] tc;
  } qtg_item_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } qtg_mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
  } qtg_div_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/qtg_front.sv -----
// front end: time clamp, zero duration flag and the item queue
// depends on qtg_pkg
`default_nettype none

module qtg_front import qtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DATA_WIDTH-1:0] sample_time_i,
  input  logic [DUR_W-1:0]      duration_i,
  output logic                  busy_o,
  input  logic                  pop_i,
  output qtg_item_t             head_o,
  output logic                  empty_o
);

  qtg_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     count_q, count_d;
  logic                full, push, pop;
  qtg_item_t           item;
  logic signed [DATA_WIDTH:0] t_ext, dur_ext;

  always_comb begin
    t_ext   = (DATA_WIDTH+1)'($signed(sample_time_i));
    dur_ext = $signed({2'b00, duration_i});
    item.zero = (duration_i == '0);
    if (t_ext >= dur_ext) begin
      item.tc = duration_i;
    end else if (t_ext <= 0) begin
      item.tc = '0;
    end else begin
      item.tc = sample_time_i[DUR_W-1:0];
    end
  end

  assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign busy_o  = full;
  assign push    = start_i && !full;
  assign pop     = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/qtg_mul.sv -----
// bit-serial unsigned multiplier, one multiplier bit per cycle
// depends on qtg_pkg
`default_nettype none

module qtg_mul import qtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qtg_mul_req_t       req_i,
  output logic [MUL_P_W-1:0] prod_o,
  output logic               done_o
);

  logic [MUL_P_W-1:0]   acc_q, acc_d, a_q, a_d;
  logic [MUL_B_W-1:0]   b_q, b_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 active_q, active_d, done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    a_d      = a_q;
    b_d      = b_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      acc_d    = '0;
      a_d      = MUL_P_W'(req_i.a);
      b_d      = req_i.b;
      cnt_d    = MUL_CNT_W'(MUL_B_W);
      active_d = 1'b1;
    end else if (active_q) begin
      if (b_q[0]) begin
        acc_d = acc_q + a_q;
      end
      a_d   = a_q << 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == MUL_CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q   <= a_d;
    b_q   <= b_d;
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/qtg_div.sv -----
// restoring divider by the duration, one quotient bit per cycle
// depends on qtg_pkg; flags quotients that run past the kept width
`default_nettype none

module qtg_div import qtg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  qtg_div_req_t     req_i,
  input  logic [DUR_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             big_o,
  output logic             done_o
);

  logic [DIV_N_W-1:0]   n_q, n_d;
  logic [DUR_W-1:0]     rem_q, rem_d;
  logic [QUO_W-1:0]     quo_q, quo_d;
  logic                 big_q, big_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 active_q, active_d, done_q, done_d;
  logic [DUR_W:0]       trial, diff;
  logic                 ge;

  always_comb begin
    trial = {rem_q, n_q[DIV_N_W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    n_d      = n_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    big_d    = big_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      n_d      = req_i.num;
      rem_d    = '0;
      quo_d    = '0;
      big_d    = 1'b0;
      cnt_d    = DIV_CNT_W'(DIV_N_W);
      active_d = 1'b1;
    end else if (active_q) begin
      rem_d = ge ? diff[DUR_W-1:0] : trial[DUR_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], ge};
      big_d = big_q | quo_q[QUO_W-1];
      n_d   = n_q << 1;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    big_q <= big_d;
  end

  assign quo_o  = quo_q;
  assign big_o  = big_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

// ----- hw/rtl/qtg_back.sv -----
// back end: sequencer over tau, its powers and the twenty hermite terms
// depends on qtg_pkg; drives the shared multiplier and divider
`default_nettype none

module qtg_back import qtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  qtg_cfg_t              cfg_i,
  input  qtg_item_t             item_i,
  input  logic                  empty_i,
  output logic                  pop_o,
  output qtg_mul_req_t          mul_req_o,
  input  logic [MUL_P_W-1:0]    mul_prod_i,
  input  logic                  mul_done_i,
  output qtg_div_req_t          div_req_o,
  input  logic [QUO_W-1:0]      div_quo_i,
  input  logic                  div_big_i,
  input  logic                  div_done_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] position_o,
  output logic [DATA_WIDTH-1:0] velocity_o,
  output logic [DATA_WIDTH-1:0] acceleration_o,
  output logic [DATA_WIDTH-1:0] jerk_o,
  output logic                  saturated_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TAU   = 3'd1;
  localparam logic [2:0] S_POW   = 3'd2;
  localparam logic [2:0] S_BAS   = 3'd3;
  localparam logic [2:0] S_CHAIN = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;

  localparam logic [1:0] SH_POW  = 2'd0;
  localparam logic [1:0] SH_MUL1 = 2'd1;
  localparam logic [1:0] SH_FRAC = 2'd2;

  localparam logic [MUL_P_W-1:0] TERM_LIMIT = MUL_P_W'(1) << TERM_BITS;
  localparam logic [63:0]        HALF       = 64'(1) << (DATA_WIDTH - 1);
  localparam logic [DUR_W-1:0]   PW_ONE     = DUR_W'(1) << TAU_BITS;
  localparam int                 BW         = 44;

  logic [2:0]            state_q, state_d;
  logic [1:0]            d_q, d_d;
  logic [2:0]            i_q, i_d, j_q, j_d, k_q, k_d;
  logic signed [2:0]     m_q, m_d;
  logic [DUR_W-1:0]      pw_q [6];
  logic [DUR_W-1:0]      pw_d [6];
  logic signed [BW-1:0]  bacc_q, bacc_d;
  logic                  neg_q, neg_d;
  logic [VAL_W-1:0]      v_q, v_d;
  logic signed [63:0]    sum_q, sum_d;
  logic                  sat_q, sat_d;
  logic [DATA_WIDTH-1:0] res_q [3];
  logic [DATA_WIDTH-1:0] res_d [3];
  logic [1:0]            sh_q, sh_d;
  logic                  use_div_q, use_div_d;
  logic                  done_q, done_d;
  logic [DATA_WIDTH-1:0] pos_q, pos_d, vel_q, vel_d, acc_q, acc_d, jerk_q, jerk_d;
  logic                  satout_q, satout_d;

  logic [MUL_P_W-1:0]    p_sh, raw;
  logic                  over, unit_done;
  logic [VAL_W-1:0]      res_v;
  logic signed [32:0]    x_cur;
  logic [32:0]           xmag;
  logic [6:0]            bidx;
  logic signed [11:0]    coef;
  logic signed [BW-1:0]  bterm, bnext, bneg;
  logic signed [63:0]    term, sum_new;
  logic [63:0]           smag, mshift;
  logic [DATA_WIDTH-1:0] fin;
  logic                  fin_sat;
  logic signed [2:0]     m_start;

  always_comb begin
    case (sh_q)
      SH_POW:  p_sh = mul_prod_i >> TAU_BITS;
      SH_MUL1: p_sh = mul_prod_i >> (TAU_BITS + 1 - GUARD_BITS);
      SH_FRAC: p_sh = mul_prod_i >> FRACTION_BITS;
      default: p_sh = mul_prod_i;
    endcase
    raw       = use_div_q ? MUL_P_W'(div_quo_i) : p_sh;
    over      = (use_div_q && div_big_i) || (raw > TERM_LIMIT);
    res_v     = over ? TERM_LIMIT[VAL_W-1:0] : raw[VAL_W-1:0];
    unit_done = use_div_q ? div_done_i : mul_done_i;
  end

  always_comb begin
    case (i_q)
      3'd0:    x_cur = 33'($signed(cfg_i.end_position)) -
                       33'($signed(cfg_i.start_position));
      3'd1:    x_cur = 33'($signed(cfg_i.start_speed));
      3'd2:    x_cur = 33'($signed(cfg_i.end_speed));
      3'd3:    x_cur = 33'($signed(cfg_i.start_accel));
      default: x_cur = 33'($signed(cfg_i.end_accel));
    endcase
    xmag    = x_cur[32] ? 33'(-x_cur) : 33'(x_cur);
    bidx    = 7'(i_q) * 7'(BAS_STRIDE_I) + 7'(d_q) * 7'(BAS_STRIDE_D) + 7'(j_q);
    coef    = 12'(BASIS_TAB[bidx]);
    bterm   = BW'(coef) * $signed({13'b0, pw_q[j_q]});
    bnext   = bacc_q + bterm;
    bneg    = -bnext;
    m_start = 3'(BASIS_TPOW[i_q]) - $signed({1'b0, d_q});
  end

  always_comb begin
    term    = neg_q ? -$signed(64'(v_q)) : $signed(64'(v_q));
    sum_new = sum_q + term;
    smag    = sum_new[63] ? 64'(-sum_new) : 64'(sum_new);
    mshift  = smag >> GUARD_BITS;
    fin_sat = 1'b0;
    if (sum_new[63]) begin
      if (mshift > HALF) begin
        fin     = HALF[DATA_WIDTH-1:0];
        fin_sat = 1'b1;
      end else begin
        fin = DATA_WIDTH'(-mshift);
      end
    end else begin
      if (mshift > HALF - 64'(1)) begin
        fin     = DATA_WIDTH'(HALF - 64'(1));
        fin_sat = 1'b1;
      end else begin
        fin = mshift[DATA_WIDTH-1:0];
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    d_d       = d_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    m_d       = m_q;
    pw_d      = pw_q;
    bacc_d    = bacc_q;
    neg_d     = neg_q;
    v_d       = v_q;
    sum_d     = sum_q;
    sat_d     = sat_q;
    res_d     = res_q;
    sh_d      = sh_q;
    use_div_d = use_div_q;
    done_d    = 1'b0;
    pos_d     = pos_q;
    vel_d     = vel_q;
    acc_d     = acc_q;
    jerk_d    = jerk_q;
    satout_d  = satout_q;
    pop_o     = 1'b0;
    mul_req_o = '0;
    div_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          sat_d = 1'b0;
          if (item_i.zero) begin
            done_d   = 1'b1;
            pos_d    = cfg_i.start_position;
            vel_d    = cfg_i.start_speed;
            acc_d    = cfg_i.start_accel;
            jerk_d   = '0;
            satout_d = 1'b0;
          end else begin
            div_req_o.start = 1'b1;
            div_req_o.num   = DIV_N_W'({item_i.tc, TAU_BITS'(0)});
            use_div_d       = 1'b1;
            state_d         = S_TAU;
          end
        end
      end
      S_TAU: begin
        if (div_done_i) begin
          pw_d[0]         = PW_ONE;
          pw_d[1]         = div_quo_i[DUR_W-1:0];
          k_d             = 3'd2;
          mul_req_o.start = 1'b1;
          mul_req_o.a     = MUL_A_W'(div_quo_i[DUR_W-1:0]);
          mul_req_o.b     = MUL_B_W'(div_quo_i[DUR_W-1:0]);
          sh_d            = SH_POW;
          use_div_d       = 1'b0;
          state_d         = S_POW;
        end
      end
      S_POW: begin
        if (mul_done_i) begin
          pw_d[k_q] = res_v[DUR_W-1:0];
          if (k_q == 3'd5) begin
            d_d     = '0;
            i_d     = '0;
            j_d     = '0;
            bacc_d  = '0;
            sum_d   = 64'($signed(cfg_i.start_position)) <<< GUARD_BITS;
            state_d = S_BAS;
          end else begin
            k_d             = k_q + 1'b1;
            mul_req_o.start = 1'b1;
            mul_req_o.a     = MUL_A_W'(res_v[DUR_W-1:0]);
            mul_req_o.b     = MUL_B_W'(pw_q[1]);
          end
        end
      end
      S_BAS: begin
        if (j_q == 3'd5) begin
          mul_req_o.start = 1'b1;
          mul_req_o.a     = MUL_A_W'(xmag);
          mul_req_o.b     = bnext[BW-1] ? bneg[MUL_B_W-1:0] : bnext[MUL_B_W-1:0];
          sh_d            = SH_MUL1;
          use_div_d       = 1'b0;
          neg_d           = x_cur[32] ^ bnext[BW-1];
          m_d             = m_start;
          state_d         = S_CHAIN;
        end else begin
          bacc_d = bnext;
          j_d    = j_q + 1'b1;
        end
      end
      S_CHAIN: begin
        if (unit_done) begin
          sat_d = sat_q | over;
          if (m_q > 0) begin
            mul_req_o.start = 1'b1;
            mul_req_o.a     = res_v;
            mul_req_o.b     = MUL_B_W'(cfg_i.duration);
            sh_d            = SH_FRAC;
            use_div_d       = 1'b0;
            m_d             = m_q - 3'sd1;
          end else if (m_q < 0) begin
            div_req_o.start = 1'b1;
            div_req_o.num   = {res_v, FRACTION_BITS'(0)};
            use_div_d       = 1'b1;
            m_d             = m_q + 3'sd1;
          end else begin
            v_d     = res_v;
            state_d = S_ACC;
          end
        end
      end
      S_ACC: begin
        j_d    = '0;
        bacc_d = '0;
        if (i_q == 3'd4) begin
          sat_d = sat_q | fin_sat;
          if (d_q == 2'd3) begin
            done_d   = 1'b1;
            pos_d    = res_q[0];
            vel_d    = res_q[1];
            acc_d    = res_q[2];
            jerk_d   = fin;
            satout_d = sat_q | fin_sat;
            state_d  = S_IDLE;
          end else begin
            res_d[d_q] = fin;
            d_d        = d_q + 1'b1;
            i_d        = '0;
            sum_d      = '0;
            state_d    = S_BAS;
          end
        end else begin
          i_d     = i_q + 1'b1;
          sum_d   = sum_new;
          state_d = S_BAS;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      d_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      k_q       <= '0;
      m_q       <= '0;
      sh_q      <= SH_POW;
      use_div_q <= 1'b0;
      done_q    <= 1'b0;
      sat_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      d_q       <= d_d;
      i_q       <= i_d;
      j_q       <= j_d;
      k_q       <= k_d;
      m_q       <= m_d;
      sh_q      <= sh_d;
      use_div_q <= use_div_d;
      done_q    <= done_d;
      sat_q     <= sat_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pw_q     <= pw_d;
    bacc_q   <= bacc_d;
    neg_q    <= neg_d;
    v_q      <= v_d;
    sum_q    <= sum_d;
    res_q    <= res_d;
    pos_q    <= pos_d;
    vel_q    <= vel_d;
    acc_q    <= acc_d;
    jerk_q   <= jerk_d;
    satout_q <= satout_d;
  end

  assign done_o         = done_q;
  assign position_o     = pos_q;
  assign velocity_o     = vel_q;
  assign acceleration_o = acc_q;
  assign jerk_o         = jerk_q;
  assign saturated_o    = satout_q;

endmodule

`default_nettype wire

// ----- hw/rtl/quintic_trajectory_generator_core.sv -----
// the 42-step serial multiplier and 76-step serial divider are shared over twenty terms
// the back end handles one sample at a time; a four-word queue takes new samples until full
// zero duration: result strobed the cycle after the word leaves the queue
// results are strobed on done_o for one cycle; the receiver cannot stall
// reset empties the queue, duration returns to 1.0 and the other config registers to zero
`default_nettype none
`include "assert_macros.svh"

module quintic_trajectory_generator_core import qtg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic [DATA_WIDTH-1:0] sample_time_i,
  output logic                  busy,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] position_o,
  output logic [DATA_WIDTH-1:0] velocity_o,
  output logic [DATA_WIDTH-1:0] acceleration_o,
  output logic [DATA_WIDTH-1:0] jerk_o,
  output logic                  saturated_o
);

  qtg_cfg_t           cfg_q;
  qtg_item_t          head;
  logic               q_empty, pop;
  qtg_mul_req_t       mul_req;
  qtg_div_req_t       div_req;
  logic [MUL_P_W-1:0] mul_prod;
  logic               mul_done;
  logic [QUO_W-1:0]   div_quo;
  logic               div_big, div_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.duration       <= DURATION_RESET;
      cfg_q.start_position <= '0;
      cfg_q.start_speed    <= '0;
      cfg_q.start_accel    <= '0;
      cfg_q.end_position   <= '0;
      cfg_q.end_speed      <= '0;
      cfg_q.end_accel      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DURATION:       cfg_q.duration       <= cfg_data_i[DUR_W-1:0];
        REG_START_POSITION: cfg_q.start_position <= cfg_data_i;
        REG_START_SPEED:    cfg_q.start_speed    <= cfg_data_i;
        REG_START_ACCEL:    cfg_q.start_accel    <= cfg_data_i;
        REG_END_POSITION:   cfg_q.end_position   <= cfg_data_i;
        REG_END_SPEED:      cfg_q.end_speed      <= cfg_data_i;
        REG_END_ACCEL:      cfg_q.end_accel      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  qtg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .sample_time_i (sample_time_i),
    .duration_i    (cfg_q.duration),
    .busy_o        (busy),
    .pop_i         (pop),
    .head_o        (head),
    .empty_o       (q_empty)
  );

  qtg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .prod_o (mul_prod),
    .done_o (mul_done)
  );

  qtg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .den_i  (cfg_q.duration),
    .quo_o  (div_quo),
    .big_o  (div_big),
    .done_o (div_done)
  );

  qtg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_i         (head),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .mul_req_o      (mul_req),
    .mul_prod_i     (mul_prod),
    .mul_done_i     (mul_done),
    .div_req_o      (div_req),
    .div_quo_i      (div_quo),
    .div_big_i      (div_big),
    .div_done_i     (div_done),
    .done_o         (done_o),
    .position_o     (position_o),
    .velocity_o     (velocity_o),
    .acceleration_o (acceleration_o),
    .jerk_o         (jerk_o),
    .saturated_o    (saturated_o)
  );

  `QTG_ASSERT_IMPL(busy_after_push_a, $rose(busy), $past(start))
  `QTG_ASSERT_IMPL(full_not_empty_a, busy, !q_empty)
  `QTG_ASSERT(units_exclusive_a, !(mul_req.start && div_req.start))

endmodule

`default_nettype wire
